[sv/qkr_pkg.sv]
// Shared types and constants for the keyed-removal queue.
// Used by qkr_store, qkr_ctrl and bounded_queue_with_keyed_removal; depends on nothing.
package qkr_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_W = 16;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_REMOVE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DATA_W-1:0] data;
	} entry_t;

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] found_data;
		logic [ID_W-1:0]   front_id;
		logic [DATA_W-1:0] front_data;
	} result_t;

endpackage

[sv/qkr_store.sv]
// Entry memory of the keyed-removal queue: one write port, one read port with
// registered read data. Depends on qkr_pkg.
module qkr_store #(
	parameter int QUEUE_DEPTH = qkr_pkg::QUEUE_DEPTH_DEF,
	localparam int AW = $clog2(QUEUE_DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  qkr_pkg::entry_t wr_entry,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output qkr_pkg::entry_t rd_entry
);
	import qkr_pkg::*;

	entry_t mem_q [QUEUE_DEPTH];
	entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_q <= mem_q[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule

[sv/qkr_ctrl.sv]
// Sequencer of the keyed-removal queue: one id comparator and the memory port
// are reused step by step for search and compaction. Depends on qkr_pkg.
module qkr_ctrl #(
	parameter int QUEUE_DEPTH = qkr_pkg::QUEUE_DEPTH_DEF,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  qkr_pkg::req_t                  req_type,
	input  logic [qkr_pkg::ID_W-1:0]       req_id,
	input  logic [qkr_pkg::DATA_W-1:0]     req_data,
	output logic                           res_valid,
	input  logic                           res_ready,
	output qkr_pkg::result_t               res,
	output logic [CW-1:0]                  res_count,
	output logic                           wr_en,
	output logic [AW-1:0]                  wr_addr,
	output qkr_pkg::entry_t                wr_entry,
	output logic                           rd_en,
	output logic [AW-1:0]                  rd_addr,
	input  qkr_pkg::entry_t                rd_entry
);
	import qkr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rp_q;
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     la_q;
	logic              rd_pend_q;
	req_t              req_q;
	logic [ID_W-1:0]   key_q;
	status_t           status_q;
	logic [DATA_W-1:0] found_q;
	entry_t            front_q;

	logic rd_issue;
	logic hit;
	logic push_ok;

	assign rd_issue = (state_q == S_SCAN || state_q == S_SHIFT) && (rp_q < count_q);
	assign rd_en    = rd_issue;
	assign rd_addr  = rp_q[AW-1:0];
	// The one comparator: the entry read last cycle against the search key.
	assign hit      = (state_q == S_SCAN) && rd_pend_q && (rd_entry.id == key_q);
	assign push_ok  = (state_q == S_IDLE) && req_valid && (req_type == REQ_PUSH)
		&& (count_q != DEPTH_C);

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = wp_q;
		wr_entry = rd_entry;
		if (push_ok) begin
			wr_en          = 1'b1;
			wr_addr        = count_q[AW-1:0];
			wr_entry.id    = req_id;
			wr_entry.data  = req_data;
		end else if (state_q == S_SHIFT && rd_pend_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= rd_issue;
			if (rd_issue) begin
				la_q <= rp_q[AW-1:0];
				rp_q <= rp_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q    <= req_type;
						key_q    <= req_id;
						found_q  <= '0;
						status_q <= STAT_OK;
						rp_q     <= '0;
						priority if (req_type == REQ_PUSH) begin
							if (count_q == DEPTH_C) begin
								status_q <= STAT_FULL;
							end else begin
								count_q <= count_q + CW'(1);
								if (count_q == '0) begin
									front_q.id   <= req_id;
									front_q.data <= req_data;
								end
							end
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							status_q <= STAT_EMPTY;
							state_q  <= S_DONE;
						end else if (req_type == REQ_POP) begin
							wp_q    <= '0;
							rp_q    <= CW'(1);
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (req_q == REQ_FIND) begin
							found_q <= rd_entry.data;
							state_q <= S_DONE;
						end else begin
							// The read already issued for the next slot feeds the shift.
							wp_q    <= la_q;
							state_q <= S_SHIFT;
						end
					end else if (!rd_issue && !rd_pend_q) begin
						status_q <= STAT_MISSING;
						state_q  <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (rd_pend_q) begin
						wp_q <= wp_q + AW'(1);
						if (wp_q == '0) begin
							front_q <= rd_entry;
						end
					end
					if (!rd_issue && !rd_pend_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall      = (state_q != S_IDLE);
	assign res_valid      = (state_q == S_DONE);
	assign res.status     = status_q;
	assign res.found_data = found_q;
	assign res.front_id   = (count_q == '0) ? '0 : front_q.id;
	assign res.front_data = (count_q == '0) ? '0 : front_q.data;
	assign res_count      = count_q;

endmodule

[sv/bounded_queue_with_keyed_removal.sv]
// Top level of the bounded queue with keyed search and removal.
// Instantiates qkr_ctrl and qkr_store; depends on qkr_pkg.
//
// This block keeps up to QUEUE_DEPTH entries (a 16-bit id and a 32-bit data
// handle) in arrival order, packed so that slot 0 of the entry memory is
// always the head. Each request transfer performs push, pop, find or remove
// and yields exactly one result transfer carrying the status, the found data
// (find only), the head entry, the entry count and an empty flag. Requests
// are handled one at a time by a small sequencer around one id comparator and
// a memory with a single write and a single read port. Push, and any request
// refused because the queue is full or empty, goes straight to its result
// without a memory read. Find reads one entry per cycle from the head until
// the first matching id. Pop and remove move every entry behind the removed
// one a slot toward the head, one entry per cycle through the same read port,
// so a remove costs the search plus the compaction.
// The finished result sits in an output register, so the next request may be
// taken while a result transfer is still stalled. The entry memory needs no
// clearing after reset: only slots below the entry count are ever read.
module bounded_queue_with_keyed_removal #(
	parameter int QUEUE_DEPTH = qkr_pkg::QUEUE_DEPTH_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  qkr_pkg::req_t              req_type,
	input  logic [qkr_pkg::ID_W-1:0]   entry_id,
	input  logic [qkr_pkg::DATA_W-1:0] entry_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output qkr_pkg::status_t           status,
	output logic [qkr_pkg::DATA_W-1:0] found_data,
	output logic [qkr_pkg::ID_W-1:0]   front_id,
	output logic [qkr_pkg::DATA_W-1:0] front_data,
	output logic [CW-1:0]              entry_count,
	output logic                       queue_empty
);
	import qkr_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic          res_valid;
	logic          res_ready;
	result_t       res;
	logic [CW-1:0] res_count;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_entry;

	logic          out_valid_q;
	result_t       out_res_q;
	logic [CW-1:0] out_count_q;

	qkr_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_stall (in_stall),
		.req_type  (req_type),
		.req_id    (entry_id),
		.req_data  (entry_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.res_count (res_count),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_entry  (wr_entry),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry)
	);

	qkr_store #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	// The output register may be reloaded when it is empty or its transfer
	// completes in this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_res_q   <= res;
				out_count_q <= res_count;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_res_q.status;
	assign found_data  = out_res_q.found_data;
	assign front_id    = out_res_q.front_id;
	assign front_data  = out_res_q.front_data;
	assign entry_count = out_count_q;
	assign queue_empty = (out_count_q == '0);

	// A full refusal can only be reported when every slot is taken.
	a_full_means_depth : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> entry_count == CW'(QUEUE_DEPTH))
		else $error("full status with free slots");

	// An empty refusal leaves the queue empty and reports no data.
	a_empty_reported : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> queue_empty && found_data == '0)
		else $error("empty status on a non-empty queue");

	// The count never exceeds the capacity.
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CW'(QUEUE_DEPTH))
		else $error("entry count above capacity");

endmodule
